// ----- design/annex_b_access_unit_splitter_defines.svh -----
// ----------------------------------------------------------------------------
// Annex-B splitter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ANNEX_B_ACCESS_UNIT_SPLITTER_DEFINES_SVH
`define ANNEX_B_ACCESS_UNIT_SPLITTER_DEFINES_SVH

// Same-cycle implication.
`define ABS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ABS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/abs_pkg.sv -----
// ----------------------------------------------------------------------------
// Annex-B splitter package
// Constants and the slice classification shared by the splitter modules.
// ----------------------------------------------------------------------------
package abs_pkg;

  localparam int unsigned ABS_POS_BITS    = 32;
  localparam int unsigned ABS_QUEUE_DEPTH = 4;
  localparam int unsigned ABS_OUT_BITS    = 32;

  localparam logic CODEC_H264 = 1'b0;
  localparam logic CODEC_H265 = 1'b1;

  localparam logic [7:0] H264_TYPE_MASK    = 8'h1F;
  localparam logic [7:0] H265_TYPE_MASK    = 8'h3F;
  localparam logic [7:0] H264_TYPE_SLICE   = 8'h01;
  localparam logic [7:0] H264_TYPE_IDR     = 8'h05;
  localparam logic [7:0] H265_SLICE_LIMIT  = 8'h20;

  typedef logic [7:0] byte_t;

  function automatic logic abs_is_slice(input byte_t hdr, input logic codec);
    byte_t t264;
    byte_t t265;
    t264 = hdr & H264_TYPE_MASK;
    t265 = (hdr >> 1) & H265_TYPE_MASK;
    if (codec == CODEC_H265) begin
      return t265 < H265_SLICE_LIMIT;
    end
    return (t264 == H264_TYPE_SLICE) || (t264 == H264_TYPE_IDR);
  endfunction

endpackage

// ----- design/abs_front.sv -----
// ----------------------------------------------------------------------------
// Annex-B splitter front end
// Scans bytes for start codes, classes NAL headers and closes access units.
// ----------------------------------------------------------------------------
module abs_front #(
  parameter int unsigned POS_BITS = abs_pkg::ABS_POS_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_codec,
  input  logic                accept_i,
  input  abs_pkg::byte_t      data_i,
  input  logic                last_i,
  output logic                res_valid_o,
  output logic [POS_BITS-1:0] res_start_o,
  output logic [POS_BITS-1:0] res_end_o,
  output logic [POS_BITS-1:0] res_slice_o
);
  import abs_pkg::*;

  logic                codec_r;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [2:0]          zeros_r, zeros_nxt;
  logic [1:0]          since_hdr_r, since_hdr_nxt;
  logic                hdr_exp_r, hdr_exp_nxt;
  logic                open_r, open_nxt;
  logic                seen_r, seen_nxt;
  logic [POS_BITS-1:0] unit_start_r, unit_start_nxt;
  logic [POS_BITS-1:0] slice_start_r, slice_start_nxt;
  logic [POS_BITS-1:0] latest_r, latest_nxt;

  logic [POS_BITS-1:0] code_start;
  logic [POS_BITS-1:0] pos_inc;
  logic                code_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_r <= CODEC_H264;
    end else if (cfg_we) begin
      codec_r <= cfg_codec;
    end
  end

  assign code_start = zeros_r[2] ? (pos_r - POS_BITS'(3)) : (pos_r - POS_BITS'(2));
  assign pos_inc    = (pos_r != '1) ? (pos_r + POS_BITS'(1)) : pos_r;
  assign code_hit   = !hdr_exp_r && (data_i == 8'h01) && (zeros_r[1:0] == 2'b11) &&
                      since_hdr_r[1];

  always_comb begin
    pos_nxt         = pos_r;
    zeros_nxt       = zeros_r;
    since_hdr_nxt   = since_hdr_r;
    hdr_exp_nxt     = hdr_exp_r;
    open_nxt        = open_r;
    seen_nxt        = seen_r;
    unit_start_nxt  = unit_start_r;
    slice_start_nxt = slice_start_r;
    latest_nxt      = latest_r;
    res_valid_o     = 1'b0;
    res_end_o       = code_start;
    if (accept_i) begin
      if (hdr_exp_r) begin
        hdr_exp_nxt   = 1'b0;
        since_hdr_nxt = 2'd0;
        if (open_r && !seen_r && abs_is_slice(data_i, codec_r)) begin
          seen_nxt        = 1'b1;
          slice_start_nxt = latest_r;
        end
      end else begin
        if (code_hit) begin
          latest_nxt = code_start;
          if (open_r && seen_r) begin
            res_valid_o    = 1'b1;
            unit_start_nxt = code_start;
            seen_nxt       = 1'b0;
          end else if (!open_r) begin
            open_nxt       = 1'b1;
            unit_start_nxt = code_start;
          end
          hdr_exp_nxt = 1'b1;
        end
        if (since_hdr_r != 2'd3) begin
          since_hdr_nxt = since_hdr_r + 2'd1;
        end
      end
      zeros_nxt = {zeros_r[1:0], data_i == 8'h00};
      pos_nxt   = pos_inc;
      if (last_i) begin
        if (!res_valid_o && open_nxt && seen_nxt) begin
          res_valid_o = 1'b1;
          res_end_o   = pos_inc;
        end
        pos_nxt         = '0;
        zeros_nxt       = 3'd0;
        since_hdr_nxt   = 2'd3;
        hdr_exp_nxt     = 1'b0;
        open_nxt        = 1'b0;
        seen_nxt        = 1'b0;
        unit_start_nxt  = '0;
        slice_start_nxt = '0;
        latest_nxt      = '0;
      end
    end
  end

  assign res_start_o = unit_start_r;
  assign res_slice_o = seen_r ? slice_start_r : latest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      zeros_r       <= 3'd0;
      since_hdr_r   <= 2'd3;
      hdr_exp_r     <= 1'b0;
      open_r        <= 1'b0;
      seen_r        <= 1'b0;
      unit_start_r  <= '0;
      slice_start_r <= '0;
      latest_r      <= '0;
    end else begin
      pos_r         <= pos_nxt;
      zeros_r       <= zeros_nxt;
      since_hdr_r   <= since_hdr_nxt;
      hdr_exp_r     <= hdr_exp_nxt;
      open_r        <= open_nxt;
      seen_r        <= seen_nxt;
      unit_start_r  <= unit_start_nxt;
      slice_start_r <= slice_start_nxt;
      latest_r      <= latest_nxt;
    end
  end

endmodule

// ----- design/abs_queue.sv -----
// ----------------------------------------------------------------------------
// Annex-B splitter result queue
// Small first-in first-out buffer between the front end and the output stage.
// ----------------------------------------------------------------------------
`include "annex_b_access_unit_splitter_defines.svh"

module abs_queue #(
  parameter int unsigned WIDTH = 3 * abs_pkg::ABS_POS_BITS,
  parameter int unsigned DEPTH = abs_pkg::ABS_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);
  import abs_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_r == CNT_W'(DEPTH));
  assign empty_o = (cnt_r == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : (wr_ptr_r + PTR_W'(1));
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : (rd_ptr_r + PTR_W'(1));
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `ABS_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= CNT_W'(DEPTH), "queue count exceeds depth")
  `ABS_ASSERT_IMP(a_no_overflow, full_o, !push_i, "result pushed into a full queue")
  `ABS_ASSERT_NXT(a_cnt_grow, do_push && !do_pop, cnt_r == $past(cnt_r) + CNT_W'(1),
                  "queue count did not grow on push")
  `ABS_ASSERT_NXT(a_cnt_drain, do_pop && !do_push, cnt_r == $past(cnt_r) - CNT_W'(1),
                  "queue count did not shrink on pop")

endmodule

// ----- design/abs_back.sv -----
// ----------------------------------------------------------------------------
// Annex-B splitter output stage
// Forms unit length and offsets and holds the result for the receiver.
// ----------------------------------------------------------------------------
module abs_back #(
  parameter int unsigned POS_BITS = abs_pkg::ABS_POS_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_empty_i,
  input  logic [3*POS_BITS-1:0]              q_data_i,
  output logic                               q_pop_o,
  input  logic                               pop_i,
  output logic                               empty_o,
  output logic [abs_pkg::ABS_OUT_BITS-1:0]   au_offset_o,
  output logic [abs_pkg::ABS_OUT_BITS-1:0]   au_length_o,
  output logic [abs_pkg::ABS_OUT_BITS-1:0]   slice_offset_o
);
  import abs_pkg::*;

  logic                    valid_r, valid_nxt;
  logic [ABS_OUT_BITS-1:0] offset_r, length_r, slice_r;
  logic [POS_BITS-1:0]     q_start, q_end, q_slice, q_len;
  logic                    load;

  assign q_start = q_data_i[3*POS_BITS-1:2*POS_BITS];
  assign q_end   = q_data_i[2*POS_BITS-1:POS_BITS];
  assign q_slice = q_data_i[POS_BITS-1:0];
  assign q_len   = q_end - q_start;

  assign load    = !q_empty_i && (!valid_r || pop_i);
  assign q_pop_o = load;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (pop_i) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      offset_r <= ABS_OUT_BITS'(q_start);
      length_r <= ABS_OUT_BITS'(q_len);
      slice_r  <= ABS_OUT_BITS'(q_slice);
    end
  end

  assign empty_o        = !valid_r;
  assign au_offset_o    = offset_r;
  assign au_length_o    = length_r;
  assign slice_offset_o = slice_r;

endmodule

// ----- design/annex_b_access_unit_splitter.sv -----
// ----------------------------------------------------------------------------
// Annex-B access unit splitter
// Splits an H.264 or H.265 Annex-B byte stream into access units.
// ----------------------------------------------------------------------------
// Input channel: one stream byte per transaction (push while full is low);
// last_byte marks the end of a stream, after which offsets restart at zero.
// Result channel: one transaction per access unit, giving the unit's offset,
// its length and the offset of its slice start code; read with pop while
// empty is low. Configuration: cfg_codec_select picks the H.264 or H.265
// slice rule and is taken on cfg_valid, with cfg_ready always high.
// Throughput is one byte per cycle while full is low. A unit is closed by
// the 01 byte of the next start code or by the stream's last byte, and its
// result is pushed into a small result queue between the scanner and the
// output register, which loads it from there. When the receiver stalls the
// queue fills, and full rises only once it holds QUEUE_DEPTH waiting results.
// Reset clears the scanner, the queue and the output, and selects H.264.
// ----------------------------------------------------------------------------
module annex_b_access_unit_splitter #(
  parameter int unsigned POS_BITS    = abs_pkg::ABS_POS_BITS,
  parameter int unsigned QUEUE_DEPTH = abs_pkg::ABS_QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_codec_select,
  input  logic                             push,
  output logic                             full,
  input  logic [7:0]                       in_data_byte,
  input  logic                             in_last_byte,
  output logic                             empty,
  input  logic                             pop,
  output logic [abs_pkg::ABS_OUT_BITS-1:0] out_au_offset,
  output logic [abs_pkg::ABS_OUT_BITS-1:0] out_au_length,
  output logic [abs_pkg::ABS_OUT_BITS-1:0] out_slice_offset
);
  import abs_pkg::*;

  logic                  accept;
  logic                  res_valid;
  logic [POS_BITS-1:0]   res_start, res_end, res_slice;
  logic [3*POS_BITS-1:0] q_wdata, q_rdata;
  logic                  q_full, q_empty, q_pop;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;
  assign q_wdata   = {res_start, res_end, res_slice};

  abs_front #(
    .POS_BITS (POS_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_codec   (cfg_codec_select),
    .accept_i    (accept),
    .data_i      (in_data_byte),
    .last_i      (in_last_byte),
    .res_valid_o (res_valid),
    .res_start_o (res_start),
    .res_end_o   (res_end),
    .res_slice_o (res_slice)
  );

  abs_queue #(
    .WIDTH (3 * POS_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (res_valid),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  abs_back #(
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty_i      (q_empty),
    .q_data_i       (q_rdata),
    .q_pop_o        (q_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .au_offset_o    (out_au_offset),
    .au_length_o    (out_au_length),
    .slice_offset_o (out_slice_offset)
  );

endmodule

// ----- tb/sv/annex_b_access_unit_splitter_tb.sv -----
// ----------------------------------------------------------------------------
// Annex-B access unit splitter testbench
// Streams H.264 and H.265 byte streams into the splitter with random stalls on
// both sides. A scanner model inside the bench predicts each access unit
// transaction, and every unit that comes out is checked against it in order.
// ----------------------------------------------------------------------------
module annex_b_access_unit_splitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import abs_pkg::*;

  localparam int IDLE_PCT      = 16;
  localparam int SETTLE_CYCLES = 8 + ABS_QUEUE_DEPTH;
  localparam int STALL_LIMIT   = 4000;

  typedef logic [ABS_POS_BITS-1:0] pos_t;
  typedef logic [ABS_OUT_BITS-1:0] out_t;

  typedef struct packed {
    byte_t data;
    logic  last;
  } stream_byte_t;

  typedef struct packed {
    out_t au_offset;
    out_t au_length;
    out_t slice_offset;
  } au_rec_t;

  logic       clk              = 1'b0;
  logic       rst_n            = 1'b0;
  logic       cfg_valid        = 1'b0;
  logic       cfg_ready;
  logic       cfg_codec_select = 1'b0;
  logic       push             = 1'b0;
  logic       full;
  logic [7:0] in_data_byte     = 8'h00;
  logic       in_last_byte     = 1'b0;
  logic       empty;
  logic       pop              = 1'b0;
  out_t       out_au_offset;
  out_t       out_au_length;
  out_t       out_slice_offset;

  stream_byte_t staged[$];
  stream_byte_t byte_pending[$];
  au_rec_t      au_expected[$];

  bit          steady_mode    = 1'b0;
  int unsigned mismatches     = 0;
  int unsigned bytes_accepted = 0;
  int unsigned units_checked  = 0;
  int unsigned streams_sent   = 0;
  int unsigned stall_cycles   = 0;

  logic codec_sel;
  pos_t scan_pos;
  logic [2:0] zero_hist;
  logic [1:0] since_hdr;
  bit   hdr_pending;
  bit   au_open;
  bit   slice_found;
  pos_t au_start;
  pos_t slice_pos;
  pos_t code_pos;

  annex_b_access_unit_splitter u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_codec_select (cfg_codec_select),
    .push             (push),
    .full             (full),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .empty            (empty),
    .pop              (pop),
    .out_au_offset    (out_au_offset),
    .out_au_length    (out_au_length),
    .out_slice_offset (out_slice_offset)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic scanner_clear();
    scan_pos    = '0;
    zero_hist   = '0;
    since_hdr   = 2'd3;
    hdr_pending = 1'b0;
    au_open     = 1'b0;
    slice_found = 1'b0;
    au_start    = '0;
    slice_pos   = '0;
    code_pos    = '0;
  endtask

  function automatic bit slice_header(input byte_t hdr);
    if (codec_sel == CODEC_H265) begin
      return {2'b00, hdr[6:1]} < H265_SLICE_LIMIT;
    end
    return hdr[4:0] == H264_TYPE_SLICE[4:0] || hdr[4:0] == H264_TYPE_IDR[4:0];
  endfunction

  function automatic au_rec_t close_unit(input pos_t end_pos);
    au_rec_t r;
    r.au_offset    = out_t'(au_start);
    r.au_length    = out_t'(end_pos - au_start);
    r.slice_offset = out_t'(slice_pos);
    return r;
  endfunction

  task automatic scan_byte(input byte_t d, input logic last);
    pos_t    p;
    pos_t    cs;
    bit      got;
    au_rec_t r;
    p   = scan_pos;
    got = 1'b0;
    if (hdr_pending) begin
      hdr_pending = 1'b0;
      since_hdr   = 2'd0;
      if (au_open && !slice_found && slice_header(d)) begin
        slice_found = 1'b1;
        slice_pos   = code_pos;
      end
    end else begin
      if (d == 8'h01 && zero_hist[1:0] == 2'b11 && since_hdr >= 2'd2) begin
        cs       = zero_hist[2] ? p - pos_t'(3) : p - pos_t'(2);
        code_pos = cs;
        if (au_open && slice_found) begin
          r           = close_unit(cs);
          got         = 1'b1;
          au_start    = cs;
          slice_found = 1'b0;
        end else if (!au_open) begin
          au_open  = 1'b1;
          au_start = cs;
        end
        hdr_pending = 1'b1;
      end
      if (since_hdr < 2'd3) begin
        since_hdr = since_hdr + 2'd1;
      end
    end
    zero_hist = {zero_hist[1:0], d == 8'h00};
    if (p != '1) begin
      scan_pos = p + pos_t'(1);
    end
    if (last) begin
      if (!got && au_open && slice_found) begin
        r   = close_unit(scan_pos);
        got = 1'b1;
      end
      scanner_clear();
    end
    if (got) begin
      au_expected.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    mismatches++;
  endtask

  task automatic stage_stream(input byte_t s[$]);
    stream_byte_t b;
    foreach (s[i]) begin
      b.data = s[i];
      b.last = (i == s.size() - 1);
      staged.push_back(b);
    end
    streams_sent++;
  endtask

  task automatic release_bytes(input int n);
    int left;
    left = n;
    @(negedge clk);
    while (left > 0 && staged.size() != 0) begin
      byte_pending.push_back(staged.pop_front());
      left--;
    end
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (!(byte_pending.size() == 0 && !push && au_expected.size() == 0));
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_codec(input logic codec);
    wait_idle();
    @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_codec_select <= codec;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    codec_sel = codec;
    cfg_valid <= 1'b0;
  endtask

  function automatic byte_t rand_header(input bit h265);
    if ($urandom_range(1) == 0) begin
      return byte_t'($urandom_range(255));
    end
    if (h265) begin
      return byte_t'($urandom_range(255)) & ~(H265_SLICE_LIMIT << 1);
    end
    return {3'($urandom_range(7)),
            ($urandom_range(1) == 0 ? H264_TYPE_SLICE[4:0] : H264_TYPE_IDR[4:0])};
  endfunction

  task automatic gen_stream(input bit h265);
    byte_t s[$];
    int    nals;
    bit    cut;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(20, 1)) begin
        s.push_back($urandom_range(2) == 0 ? 8'h00 : byte_t'($urandom_range(255)));
      end
    end else begin
      repeat ($urandom_range(2)) s.push_back(byte_t'($urandom_range(255)));
      nals = $urandom_range(5, 1);
      cut  = 1'b0;
      for (int i = 0; i < nals && !cut; i++) begin
        if ($urandom_range(2) == 0) begin
          s.push_back(8'h00);
        end
        s.push_back(8'h00);
        s.push_back(8'h00);
        s.push_back(8'h01);
        if (i == nals - 1 && $urandom_range(7) == 0) begin
          cut = 1'b1;
        end else begin
          s.push_back(rand_header(h265));
          repeat ($urandom_range(10)) begin
            s.push_back($urandom_range(99) < 12 ? 8'h00 : byte_t'($urandom_range(255, 1)));
          end
        end
      end
    end
    stage_stream(s);
  endtask

  task automatic run_random(input logic codec, input int n_items, input bit pause_mid);
    set_codec(codec);
    while (staged.size() < n_items) begin
      gen_stream(codec == CODEC_H265);
    end
    if (pause_mid) begin
      release_bytes(staged.size() / 2);
      wait_idle();
    end
    release_bytes(staged.size());
  endtask

  always @(posedge clk) begin : sender
    stream_byte_t nxt;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        scan_byte(in_data_byte, in_last_byte);
        bytes_accepted++;
      end
      if (!push || !full) begin
        if (byte_pending.size() != 0 && (steady_mode || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = byte_pending.pop_front();
          push         <= 1'b1;
          in_data_byte <= nxt.data;
          in_last_byte <= nxt.last;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    au_rec_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (au_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected unit: offset %0d length %0d slice %0d",
                                    out_au_offset, out_au_length, out_slice_offset));
        end else begin
          want = au_expected.pop_front();
          units_checked++;
          if (out_au_offset !== want.au_offset) begin
            report_mismatch($sformatf("unit %0d au_offset: got %0d, expected %0d",
                                      units_checked, out_au_offset, want.au_offset));
          end
          if (out_au_length !== want.au_length) begin
            report_mismatch($sformatf("unit %0d au_length: got %0d, expected %0d",
                                      units_checked, out_au_length, want.au_length));
          end
          if (out_slice_offset !== want.slice_offset) begin
            report_mismatch($sformatf("unit %0d slice_offset: got %0d, expected %0d",
                                      units_checked, out_slice_offset, want.slice_offset));
          end
        end
      end
      pop <= steady_mode || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("ERROR: no transaction for %0d cycles, %0d units still expected",
                 stall_cycles, au_expected.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : stimulus
    byte_t seq[$];
    codec_sel = CODEC_H264;
    scanner_clear();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // H.264: long first code, non-slice header, header zeros that are too close
    // to a following 01, a header byte of 01, and a code on the last byte.
    set_codec(CODEC_H264);
    seq = {8'h00, 8'h00, 8'h00, 8'h01, 8'h09, 8'h00, 8'h00, 8'h01,
           8'h65, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h00,
           8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 8'h01};
    stage_stream(seq);
    release_bytes(staged.size());

    // H.265: a slice unit closed by the next code, then a tail with no slice.
    set_codec(CODEC_H265);
    seq = {8'h00, 8'h00, 8'h01, 8'h26, 8'h00, 8'h00, 8'h01, 8'h40, 8'h77};
    stage_stream(seq);
    release_bytes(staged.size());

    run_random(CODEC_H264, 250, 1'b1);
    run_random(CODEC_H265, 250, 1'b0);
    wait_idle();
    steady_mode = 1'b1;
    run_random(CODEC_H264, 200, 1'b0);
    wait_idle();
    steady_mode = 1'b0;

    $display("Covered %0d streams, %0d bytes and %0d access units under both slice rules,",
             streams_sent, bytes_accepted, units_checked);
    $display("with random stalls on both channels, a drain pause and a stall-free stretch.");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
